FILE: sv/acl_pkg.sv
// shared types and codes for the atom chain layout checker
package acl_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BUF_SIZE      = 3'd0,
		CFG_ID_DATA       = 3'd1,
		CFG_ID_END        = 3'd2,
		CFG_ID_FREE       = 3'd3,
		CFG_ID_VECTOR     = 3'd4,
		CFG_ID_REFERENCE  = 3'd5
	} cfg_index_t;

	// verdict codes
	typedef enum logic [1:0] {
		V_PENDING = 2'd0,
		V_VALID   = 2'd1,
		V_INVALID = 2'd2,
		V_IGNORED = 2'd3
	} verdict_t;

	// error codes
	typedef enum logic [3:0] {
		E_NONE          = 4'd0,
		E_BUF_SIZE      = 4'd1,
		E_DATA_ATOM     = 4'd2,
		E_DATA_OVERRUN  = 4'd3,
		E_MISALIGNED    = 4'd4,
		E_OVERRUN       = 4'd5,
		E_EMPTY_ALLOC   = 4'd6,
		E_DOUBLE_FREE   = 4'd7,
		E_BAD_ID        = 4'd8,
		E_BACK_LINK     = 4'd9,
		E_BAD_END       = 4'd10
	} err_t;

	// buffer check phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_RUN  = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	// one atom header
	typedef struct packed {
		logic        first_atom;
		logic [31:0] atom_length;
		logic [31:0] atom_id;
		logic [31:0] back_link;
	} item_t;

	// one result
	typedef struct packed {
		verdict_t verdict;
		err_t     error_code;
	} result_t;

	// running state of the chain walk
	typedef struct packed {
		phase_t      phase;
		logic [31:0] remaining_bytes;
		logic [31:0] last_length;
		logic        last_was_free;
	} state_t;

	// configuration registers
	typedef struct packed {
		logic [31:0] buf_size;
		logic [31:0] id_data;
		logic [31:0] id_end;
		logic [31:0] id_free;
		logic [31:0] id_vector;
		logic [31:0] id_reference;
	} cfg_t;

endpackage

FILE: sv/acl_if.sv
// handshake interfaces for atom headers and check results

interface acl_item_if;
	logic        valid;
	logic        ready;
	logic        first_atom;
	logic [31:0] atom_length;
	logic [31:0] atom_id;
	logic [31:0] back_link;

	modport source (output valid, output first_atom, output atom_length, output atom_id,
		output back_link, input ready);
	modport sink (input valid, input first_atom, input atom_length, input atom_id,
		input back_link, output ready);
endinterface

interface acl_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [3:0] error_code;

	modport source (output valid, output verdict, output error_code, input ready);
	modport sink (input valid, input verdict, input error_code, output ready);
endinterface

FILE: sv/atom_chain_layout_checker.sv
// top level of the atom chain layout checker
// Takes one atom header per transaction in memory order, first_atom set on the
// first header of a buffer, and returns one verdict per header: pending, valid,
// invalid with an error code, or ignored outside a buffer. Headers enter an
// input register and are judged there against the registered chain state and
// configuration; the verdict goes to an output register in the same step, so a
// new header is accepted every cycle while the result side does not stall, and
// each result is offered from the output register once its header leaves the
// input register. The rate is set by the single compare-and-subtract pass on
// the chain state, which must finish before the next header is judged. The
// configuration is written through a plain write port; the user must write it
// only while no header is in flight, which the block itself does not enforce.
module atom_chain_layout_checker #(
	parameter int ALIGN_BYTES  = 16,
	parameter int HEADER_BYTES = 16,
	parameter int MIN_CONTENTS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [acl_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [31:0]                        cfg_data,
	acl_item_if.sink                           atom,
	acl_result_if.source                       report
);
	import acl_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_eval;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buf_size      <= 32'd0;
			cfg_q.id_data       <= 32'd1;
			cfg_q.id_end        <= 32'd2;
			cfg_q.id_free       <= 32'd3;
			cfg_q.id_vector     <= 32'd4;
			cfg_q.id_reference  <= 32'd5;
		end else if (cfg_write_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BUF_SIZE:      cfg_q.buf_size      <= cfg_data;
				CFG_ID_DATA:       cfg_q.id_data       <= cfg_data;
				CFG_ID_END:        cfg_q.id_end        <= cfg_data;
				CFG_ID_FREE:       cfg_q.id_free       <= cfg_data;
				CFG_ID_VECTOR:     cfg_q.id_vector     <= cfg_data;
				CFG_ID_REFERENCE:  cfg_q.id_reference  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: the input stage moves on when the output register is free or drains
	assign advance    = valid_s1 && (!valid_s2 || report.ready);
	assign atom.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (atom.valid && atom.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (atom.valid && atom.ready) begin
			item_s1.first_atom  <= atom.first_atom;
			item_s1.atom_length <= atom.atom_length;
			item_s1.atom_id     <= atom.atom_id;
			item_s1.back_link   <= atom.back_link;
		end
	end

	// header check against chain state
	acl_eval #(
		.ALIGN_BYTES  (ALIGN_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MIN_CONTENTS (MIN_CONTENTS)
	) u_eval (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_next),
		.res  (result_eval)
	);

	// chain state commits when the header's result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_IDLE;
			state_q.remaining_bytes <= 32'd0;
			state_q.last_length     <= 32'd0;
			state_q.last_was_free   <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (report.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_eval;
		end
	end

	assign report.valid      = valid_s2;
	assign report.verdict    = result_s2.verdict;
	assign report.error_code = result_s2.error_code;

endmodule

FILE: sv/acl_align_check.sv
// alignment test of a 32-bit value against a constant byte alignment
module acl_align_check #(
	parameter int ALIGN_BYTES = 16
) (
	input  logic [31:0] value,
	output logic        aligned
);

	// count of trailing zero bits of the alignment
	function automatic int trailing_zeros(input int v);
		int n;
		int w;
		n = 0;
		w = v;
		for (int i = 0; i < 7; i++) begin
			if (w[0] == 1'b0) begin
				n = n + 1;
				w = w >>> 1;
			end
		end
		return n;
	endfunction

	// multiplicative inverse of an odd number modulo 2^32 (newton steps)
	function automatic logic [31:0] inverse32(input logic [31:0] o);
		logic [31:0] y;
		y = o;
		for (int i = 0; i < 5; i++) begin
			y = y * (32'd2 - o * y);
		end
		return y;
	endfunction

	localparam int          SHIFT    = trailing_zeros(ALIGN_BYTES);
	localparam int          ODD      = ALIGN_BYTES >> SHIFT;
	localparam logic [31:0] INV      = inverse32(32'(ODD));
	localparam logic [31:0] LIMIT    = 32'(64'd4294967295 / ODD);
	localparam logic [31:0] LOW_MASK = 32'((64'd1 << SHIFT) - 64'd1);

	logic [31:0] shifted;
	logic [31:0] product;

	// power-of-two part is a mask, odd part is an inverse multiply and bound
	assign shifted = value >> SHIFT;
	assign product = shifted * INV;
	assign aligned = ((value & LOW_MASK) == 32'd0) && (product <= LIMIT);

endmodule

FILE: sv/acl_eval.sv
// decision logic for one atom header against the running chain state
module acl_eval #(
	parameter int ALIGN_BYTES  = 16,
	parameter int HEADER_BYTES = 16,
	parameter int MIN_CONTENTS = 32
) (
	input  acl_pkg::item_t   item,
	input  acl_pkg::cfg_t    cfg,
	input  acl_pkg::state_t  cur,
	output acl_pkg::state_t  nxt,
	output acl_pkg::result_t res
);
	import acl_pkg::*;

	localparam logic [31:0] HDR = 32'(HEADER_BYTES);
	localparam logic [31:0] MIN = 32'(MIN_CONTENTS);

	logic        len_aligned;
	logic        bl_aligned;
	logic [32:0] data_span;
	err_t        mid_err;
	logic        mid_is_free;

	// alignment units for the atom length and the buffer length
	acl_align_check #(.ALIGN_BYTES(ALIGN_BYTES)) u_len_align (
		.value   (item.atom_length),
		.aligned (len_aligned)
	);

	acl_align_check #(.ALIGN_BYTES(ALIGN_BYTES)) u_bl_align (
		.value   (cfg.buf_size),
		.aligned (bl_aligned)
	);

	// data atom plus closing header, without wrap
	assign data_span = {1'b0, item.atom_length} + {1'b0, HDR};

	// middle atom checks in priority order
	always_comb begin
		mid_err     = E_NONE;
		mid_is_free = 1'b0;
		if (!len_aligned) begin
			mid_err = E_MISALIGNED;
		end else if (item.atom_length > cur.remaining_bytes || item.atom_length < HDR) begin
			mid_err = E_OVERRUN;
		end else if (item.atom_id == cfg.id_vector || item.atom_id == cfg.id_reference) begin
			if (item.atom_length == HDR) begin
				mid_err = E_EMPTY_ALLOC;
			end else if (item.back_link != cur.last_length) begin
				mid_err = E_BACK_LINK;
			end
		end else if (item.atom_id == cfg.id_free) begin
			mid_is_free = 1'b1;
			if (cur.last_was_free) begin
				mid_err = E_DOUBLE_FREE;
			end else if (item.back_link != cur.last_length) begin
				mid_err = E_BACK_LINK;
			end
		end else begin
			mid_err = E_BAD_ID;
		end
	end

	// verdict and next state
	always_comb begin
		nxt            = cur;
		res.verdict    = V_PENDING;
		res.error_code = E_NONE;
		if (item.first_atom) begin
			if (!bl_aligned || cfg.buf_size < MIN) begin
				nxt.phase      = PH_DONE;
				res.verdict    = V_INVALID;
				res.error_code = E_BUF_SIZE;
			end else if (item.atom_id != cfg.id_data || !len_aligned
					|| item.atom_length < HDR || item.back_link != 32'd0) begin
				nxt.phase      = PH_DONE;
				res.verdict    = V_INVALID;
				res.error_code = E_DATA_ATOM;
			end else if (data_span > {1'b0, cfg.buf_size}) begin
				nxt.phase      = PH_DONE;
				res.verdict    = V_INVALID;
				res.error_code = E_DATA_OVERRUN;
			end else begin
				nxt.phase           = PH_RUN;
				nxt.remaining_bytes = cfg.buf_size - item.atom_length - HDR;
				nxt.last_length     = item.atom_length;
				nxt.last_was_free   = 1'b0;
			end
		end else begin
			unique case (cur.phase)
				PH_RUN: begin
					if (cur.remaining_bytes == 32'd0) begin
						nxt.phase = PH_DONE;
						if (item.atom_id != cfg.id_end || item.atom_length != HDR) begin
							res.verdict    = V_INVALID;
							res.error_code = E_BAD_END;
						end else begin
							res.verdict = V_VALID;
						end
					end else if (mid_err != E_NONE) begin
						nxt.phase      = PH_DONE;
						res.verdict    = V_INVALID;
						res.error_code = mid_err;
					end else begin
						nxt.remaining_bytes = cur.remaining_bytes - item.atom_length;
						nxt.last_length     = item.atom_length;
						nxt.last_was_free   = mid_is_free;
					end
				end
				PH_IDLE, PH_DONE: begin
					res.verdict = V_IGNORED;
				end
				default: begin
					res.verdict = V_IGNORED;
				end
			endcase
		end
	end

endmodule

FILE: sim/atom_chain_layout_checker_tb.sv
// testbench for the atom chain layout checker: directed and random header streams
`timescale 1ns / 1ps

module atom_chain_layout_checker_tb;
	import acl_pkg::*;

	localparam int unsigned ALIGN_BYTES  = 16;
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned MIN_CONTENTS = 32;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;

	acl_item_if   atom_if ();
	acl_result_if report_if ();

	atom_chain_layout_checker #(
		.ALIGN_BYTES (ALIGN_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MIN_CONTENTS(MIN_CONTENTS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.atom        (atom_if),
		.report      (report_if)
	);

	// headers waiting to be sent and verdicts waiting to arrive
	item_t   headers_to_send[$];
	result_t expected_verdicts[$];

	// register values as last written, starting from the reset values
	cfg_t cfg_now = '{buf_size: 32'd0, id_data: 32'd1, id_end: 32'd2, id_free: 32'd3,
		id_vector: 32'd4, id_reference: 32'd5};

	// predicted chain walk state
	phase_t      chain_phase     = PH_IDLE;
	logic [31:0] chain_rem       = '0;
	logic [31:0] chain_last_len  = '0;
	logic        chain_last_free = 1'b0;

	// 0: sender 17% idle, receiver 55%; 1: the reverse; 2: no idling
	int          idle_mode     = 0;
	int unsigned hold_left;
	logic        hold_done;

	int fail_count     = 0;
	int verdicts_seen  = 0;
	int headers_taken  = 0;
	int settings_count = 0;
	int n_pending      = 0;
	int n_valid        = 0;
	int n_invalid      = 0;
	int n_ignored      = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset and known input values from time zero
	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_BUF_SIZE;
		cfg_data = '0;
		atom_if.valid = 1'b0;
		atom_if.first_atom = 1'b0;
		atom_if.atom_length = '0;
		atom_if.atom_id = '0;
		atom_if.back_link = '0;
		report_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// run limit
	initial begin
		#3000000;
		$display("** atom_chain_layout_checker: FAILED **");
		$finish;
	end

	function automatic bit sender_gap();
		case (idle_mode)
			0: return $urandom_range(99, 0) < 17;
			1: return $urandom_range(99, 0) < 55;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_gap();
		case (idle_mode)
			0: return $urandom_range(99, 0) < 55;
			1: return $urandom_range(99, 0) < 17;
			default: return 1'b0;
		endcase
	endfunction

	// a failed check ends the buffer
	function automatic result_t reject(input err_t code);
		chain_phase = PH_DONE;
		return result_t'{verdict: V_INVALID, error_code: code};
	endfunction

	// expected verdict for one header, advancing the predicted chain state
	function automatic result_t judge_header(input item_t h);
		logic is_free;
		is_free = 1'b0;
		if (h.first_atom) begin
			if (cfg_now.buf_size % ALIGN_BYTES != 0 || cfg_now.buf_size < MIN_CONTENTS)
				return reject(E_BUF_SIZE);
			if (h.atom_id != cfg_now.id_data || h.atom_length % ALIGN_BYTES != 0 ||
					h.atom_length < HEADER_BYTES || h.back_link != 0)
				return reject(E_DATA_ATOM);
			if ({1'b0, h.atom_length} + 33'(HEADER_BYTES) > {1'b0, cfg_now.buf_size})
				return reject(E_DATA_OVERRUN);
			chain_rem = cfg_now.buf_size - h.atom_length - HEADER_BYTES;
			chain_last_len = h.atom_length;
			chain_last_free = 1'b0;
			chain_phase = PH_RUN;
			return result_t'{verdict: V_PENDING, error_code: E_NONE};
		end
		if (chain_phase != PH_RUN)
			return result_t'{verdict: V_IGNORED, error_code: E_NONE};
		// distance used up: only the end atom may follow
		if (chain_rem == 0) begin
			if (h.atom_id != cfg_now.id_end || h.atom_length != HEADER_BYTES)
				return reject(E_BAD_END);
			chain_phase = PH_DONE;
			return result_t'{verdict: V_VALID, error_code: E_NONE};
		end
		if (h.atom_length % ALIGN_BYTES != 0)
			return reject(E_MISALIGNED);
		if (h.atom_length > chain_rem || h.atom_length < HEADER_BYTES)
			return reject(E_OVERRUN);
		if (h.atom_id == cfg_now.id_vector || h.atom_id == cfg_now.id_reference) begin
			if (h.atom_length == HEADER_BYTES)
				return reject(E_EMPTY_ALLOC);
		end else if (h.atom_id == cfg_now.id_free) begin
			if (chain_last_free)
				return reject(E_DOUBLE_FREE);
			is_free = 1'b1;
		end else begin
			return reject(E_BAD_ID);
		end
		if (h.back_link != chain_last_len)
			return reject(E_BACK_LINK);
		chain_rem = chain_rem - h.atom_length;
		chain_last_len = h.atom_length;
		chain_last_free = is_free;
		return result_t'{verdict: V_PENDING, error_code: E_NONE};
	endfunction

	// header driver: predicts each accepted transaction, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		item_t taken;
		item_t nxt;
		if (!arst_n) begin
			atom_if.valid <= 1'b0;
		end else begin
			if (atom_if.valid && atom_if.ready) begin
				taken.first_atom = atom_if.first_atom;
				taken.atom_length = atom_if.atom_length;
				taken.atom_id = atom_if.atom_id;
				taken.back_link = atom_if.back_link;
				expected_verdicts.push_back(judge_header(taken));
				headers_taken++;
			end
			if (!atom_if.valid || atom_if.ready) begin
				if (headers_to_send.size() != 0 && !sender_gap()) begin
					nxt = headers_to_send.pop_front();
					atom_if.valid <= 1'b1;
					atom_if.first_atom <= nxt.first_atom;
					atom_if.atom_length <= nxt.atom_length;
					atom_if.atom_id <= nxt.atom_id;
					atom_if.back_link <= nxt.back_link;
				end else begin
					atom_if.valid <= 1'b0;
				end
			end
		end
	end

	// result ready, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_if.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			report_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && verdicts_seen >= 100) begin
			report_if.ready <= 1'b0;
			hold_left <= 300;
			hold_done <= 1'b1;
		end else begin
			report_if.ready <= !receiver_gap();
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && report_if.valid && report_if.ready) begin
			verdicts_seen++;
			case (report_if.verdict)
				V_PENDING: n_pending++;
				V_VALID:   n_valid++;
				V_INVALID: n_invalid++;
				default:   n_ignored++;
			endcase
			if (expected_verdicts.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none, actual verdict %0d error %0d",
					$time, report_if.verdict, report_if.error_code);
			end else begin
				want = expected_verdicts.pop_front();
				if (report_if.verdict !== want.verdict) begin
					fail_count++;
					$display("%0t: verdict mismatch, expected %0d, actual %0d",
						$time, want.verdict, report_if.verdict);
				end
				if (report_if.error_code !== want.error_code) begin
					fail_count++;
					$display("%0t: error code mismatch, expected %0d, actual %0d",
						$time, want.error_code, report_if.error_code);
				end
			end
		end
	end

	task automatic queue_header(input logic f, input logic [31:0] len, input logic [31:0] id,
			input logic [31:0] back);
		item_t h;
		h.first_atom = f;
		h.atom_length = len;
		h.atom_id = id;
		h.back_link = back;
		headers_to_send.push_back(h);
	endtask

	// wait until every transaction is sent and answered, then let the pipeline settle
	task automatic drain();
		while (headers_to_send.size() != 0 || atom_if.valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all six registers on consecutive cycles
	task automatic load_config(input cfg_t c);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_BUF_SIZE;
		cfg_data <= c.buf_size;
		@(posedge clk);
		cfg_index <= CFG_ID_DATA;
		cfg_data <= c.id_data;
		@(posedge clk);
		cfg_index <= CFG_ID_END;
		cfg_data <= c.id_end;
		@(posedge clk);
		cfg_index <= CFG_ID_FREE;
		cfg_data <= c.id_free;
		@(posedge clk);
		cfg_index <= CFG_ID_VECTOR;
		cfg_data <= c.id_vector;
		@(posedge clk);
		cfg_index <= CFG_ID_REFERENCE;
		cfg_data <= c.id_reference;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cfg_now = c;
		settings_count++;
	endtask

	// one buffer walk, well formed unless one header gets damaged on purpose
	task automatic add_chain(input cfg_t c, inout int count);
		logic [31:0] rem, len, id, back, prev, e_len, e_id, e_back;
		logic        f, last_free, is_free;
		int          pos, bad_at, kind;
		int unsigned units;
		bit          stop;
		if (c.buf_size < MIN_CONTENTS || c.buf_size % ALIGN_BYTES != 0) begin
			queue_header(1'b1, HEADER_BYTES, c.id_data, 32'd0);
			count++;
			return;
		end
		bad_at = ($urandom_range(9, 0) < 3) ? int'($urandom_range(6, 0)) : -1;
		kind = $urandom_range(5, 0);
		rem = '0;
		prev = '0;
		last_free = 1'b0;
		pos = 0;
		stop = 1'b0;
		while (!stop) begin
			is_free = 1'b0;
			f = 1'b0;
			if (pos == 0) begin
				// data atom, sometimes filling the whole buffer
				units = (c.buf_size - HEADER_BYTES) / 16;
				len = ($urandom_range(3, 0) == 0) ? units * 16 : 16 * $urandom_range(units, 1);
				id = c.id_data;
				back = '0;
				f = 1'b1;
			end else if (rem == 0) begin
				len = HEADER_BYTES;
				id = c.id_end;
				back = ($urandom_range(1, 0) != 0) ? prev : $urandom;
				stop = 1'b1;
			end else begin
				// middle atom; never leave a lone header-sized gap after a free atom
				units = rem / 16;
				if (pos >= 6 || $urandom_range(9, 0) < 3)
					len = rem;
				else
					len = 16 * $urandom_range(units, 1);
				if (len == HEADER_BYTES && (last_free || rem == 32))
					len = 32;
				if (len == HEADER_BYTES) begin
					is_free = 1'b1;
				end else begin
					case ($urandom_range(2, 0))
						0: id = c.id_vector;
						1: id = c.id_reference;
						default: is_free = 1'b1;
					endcase
					if (is_free && (last_free || rem - len == HEADER_BYTES)) begin
						is_free = 1'b0;
						id = c.id_vector;
					end
				end
				if (is_free)
					id = c.id_free;
				back = prev;
			end
			e_len = len;
			e_id = id;
			e_back = back;
			if (pos == bad_at) begin
				case (kind)
					0: e_len = len ^ $urandom_range(15, 1);
					1: e_len = (pos == 0) ? c.buf_size : rem + 16 * $urandom_range(4, 1);
					2: e_id = $urandom;
					3: e_back = back ^ ($urandom | 32'd1);
					4: begin
						e_len = HEADER_BYTES;
						e_id = c.id_vector;
					end
					default: stop = 1'b1;
				endcase
			end
			queue_header(f, e_len, e_id, e_back);
			count++;
			if (pos == 0)
				rem = c.buf_size - len - HEADER_BYTES;
			else if (!stop)
				rem = rem - len;
			prev = len;
			last_free = is_free;
			pos++;
		end
	endtask

	// stimulus
	initial begin
		cfg_t c;
		int   n;
		@(posedge arst_n);
		@(posedge clk);

		// reset values: zero buffer length rejects every buffer
		queue_header(1'b0, 32'd0, 32'd0, 32'd0);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		drain();

		// one of each error but the buffer size error, a full valid buffer and a bad end
		c = '{buf_size: 32'd256, id_data: 32'd1, id_end: 32'd2, id_free: 32'd3,
			id_vector: 32'd4, id_reference: 32'd5};
		load_config(c);
		queue_header(1'b1, 32'd16, 32'd9, 32'd0);
		queue_header(1'b1, 32'd16, 32'd1, 32'd16);
		queue_header(1'b1, 32'd256, 32'd1, 32'd0);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		queue_header(1'b0, 32'd20, 32'd4, 32'd32);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		queue_header(1'b0, 32'd224, 32'd4, 32'd32);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		queue_header(1'b0, 32'd16, 32'd4, 32'd32);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		queue_header(1'b0, 32'd32, 32'd3, 32'd32);
		queue_header(1'b0, 32'd32, 32'd3, 32'd32);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		queue_header(1'b0, 32'd32, 32'd7, 32'd32);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		queue_header(1'b0, 32'd32, 32'd5, 32'd0);
		queue_header(1'b1, 32'd32, 32'd1, 32'd0);
		queue_header(1'b0, 32'd64, 32'd3, 32'd32);
		queue_header(1'b0, 32'd144, 32'd5, 32'd64);
		queue_header(1'b0, 32'd16, 32'd2, 32'd144);
		queue_header(1'b0, 32'd0, 32'd0, 32'd0);
		queue_header(1'b1, 32'd240, 32'd1, 32'd0);
		queue_header(1'b0, 32'd32, 32'd2, 32'd0);
		drain();

		// largest aligned buffer, extreme ids: data overrun without wrap, then a tight fit
		c = '{buf_size: 32'hFFFF_FFF0, id_data: 32'h0000_0000, id_end: 32'hFFFF_FFFF,
			id_free: 32'h7FFF_FFFF, id_vector: 32'h8000_0000, id_reference: 32'h5555_AAAA};
		load_config(c);
		queue_header(1'b1, 32'hFFFF_FFF0, 32'h0, 32'd0);
		queue_header(1'b1, 32'hFFFF_FFE0, 32'h0, 32'd0);
		queue_header(1'b0, 32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFE0);
		drain();

		// misaligned buffer length
		c.buf_size = 32'hFFFF_FFFF;
		load_config(c);
		queue_header(1'b1, 32'd16, 32'h0, 32'd0);
		drain();

		// smallest buffer: data header then end
		c.buf_size = MIN_CONTENTS;
		load_config(c);
		queue_header(1'b1, 32'd16, 32'h0, 32'd0);
		queue_header(1'b0, 32'd16, 32'hFFFF_FFFF, 32'd16);
		drain();

		// random buffers under changing settings and idling patterns
		for (int p = 0; p < 9; p++) begin
			idle_mode = p / 3;
			c.id_data = $urandom;
			c.id_end = $urandom;
			c.id_free = $urandom;
			c.id_vector = $urandom;
			c.id_reference = $urandom;
			if (p == 4)
				c.buf_size = ($urandom | 32'h0000_1000) & 32'hFFFF_FFF0;
			else if (p % 2 == 0)
				c.buf_size = 16 * $urandom_range(24, 2);
			else
				c.buf_size = 16 * $urandom_range(64, 2);
			load_config(c);
			n = 0;
			while (n < 55) begin
				if ($urandom_range(99, 0) < 12)
					queue_header(1'($urandom_range(1, 0)), $urandom, $urandom, $urandom);
				else
					add_chain(c, n);
			end
			drain();
		end

		$display("covered %0d headers under %0d register settings, with one long result stall",
			headers_taken, settings_count);
		$display("verdicts: %0d pending, %0d valid, %0d invalid, %0d ignored",
			n_pending, n_valid, n_invalid, n_ignored);
		if (fail_count == 0)
			$display("** atom_chain_layout_checker: PASSED **");
		else
			$display("** atom_chain_layout_checker: FAILED **");
		$finish;
	end

endmodule
